// ===== design/spimrb_pkg.sv =====
// Shared types, register map constants and helpers for the SPI master register block.
package spimrb_pkg;

	localparam int BYTE_BITS = 8;

	// Item function codes.
	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_TICK  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// Register byte offsets.
	localparam logic [5:0] OFF_CR1  = 6'h00;
	localparam logic [5:0] OFF_CR2  = 6'h04;
	localparam logic [5:0] OFF_CFG1 = 6'h08;
	localparam logic [5:0] OFF_CFG2 = 6'h0C;
	localparam logic [5:0] OFF_IER  = 6'h10;
	localparam logic [5:0] OFF_SR   = 6'h14;
	localparam logic [5:0] OFF_IFCR = 6'h18;
	localparam logic [5:0] OFF_TXDR = 6'h20;
	localparam logic [5:0] OFF_RXDR = 6'h30;

	// Register bit positions.
	localparam int CR1_SPE       = 0;
	localparam int CTRL_START    = 9;
	localparam int CFG_MASTER    = 22;
	localparam int CFG_LSB_FIRST = 23;
	localparam int CFG_PHASE     = 24;
	localparam int CFG_POLARITY  = 25;
	localparam int CFG_SOFT_SEL  = 26;
	localparam int IRQ_EN_END    = 3;
	localparam int SR_RXP        = 0;
	localparam int SR_TXP        = 1;
	localparam int SR_EOT        = 3;
	localparam int SR_OVR        = 6;
	localparam int SR_TXC        = 12;
	localparam int CLR_END       = 3;
	localparam int IFCR_TXTFC    = 4;
	localparam int CLR_OVERRUN   = 6;
	localparam int DSIZE_BITS    = 5;

	// Positions inside the internal mode and flag vectors.
	localparam int MB_MASTER = 0;
	localparam int MB_SSM    = 1;
	localparam int MB_CPHA   = 2;
	localparam int MB_CPOL   = 3;
	localparam int MB_LSB    = 4;
	localparam int ST_EOT    = 0;
	localparam int ST_TXC    = 1;
	localparam int ST_OVR    = 2;

	typedef struct packed {
		func_t                 func;
		logic [5:0]            reg_offset;
		logic [31:0]           write_data;
		logic [BYTE_BITS-1:0]  peer_byte;
	} item_t;

	typedef struct packed {
		logic [31:0]           read_data;
		logic                  mosi_valid;
		logic [BYTE_BITS-1:0]  mosi_byte;
		logic                  irq;
		logic                  busy_res;
	} result_t;

	function automatic logic [BYTE_BITS-1:0] bit_rev(input logic [BYTE_BITS-1:0] v);
		logic [BYTE_BITS-1:0] r;
		for (int i = 0; i < BYTE_BITS; i++) begin
			r[i] = v[BYTE_BITS-1-i];
		end
		return r;
	endfunction

endpackage

// ===== design/spimrb_core.sv =====
// Register file, transfer counters and holding bytes with their combinational update logic, registered on fire.
module spimrb_core
	import spimrb_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	logic                  enable_q, enable_n;
	logic                  active_q, active_n;
	logic [COUNT_BITS-1:0] tsize_q, tsize_n;
	logic [COUNT_BITS-1:0] loads_q, loads_n;
	logic [COUNT_BITS-1:0] exch_q, exch_n;
	logic [COUNT_BITS-1:0] exch_dec;
	logic [DSIZE_BITS-1:0] dsize_q, dsize_n;
	logic [4:0]            mode_q, mode_n;
	logic                  eotie_q, eotie_n;
	logic [BYTE_BITS-1:0]  txh_q, txh_n;
	logic                  txf_q, txf_n;
	logic [BYTE_BITS-1:0]  rxh_q, rxh_n;
	logic                  rxf_q, rxf_n;
	logic [2:0]            flags_q, flags_n;
	logic                  tx_ready;
	logic                  lsb;
	logic [31:0]           rdata;
	logic [31:0]           d;

	assign tx_ready = enable_q && active_q && (loads_q != '0) && !txf_q;
	assign lsb      = mode_q[MB_LSB];
	assign d        = item.write_data;
	assign exch_dec = exch_q - COUNT_BITS'(1);

	always_comb begin
		enable_n = enable_q;
		active_n = active_q;
		tsize_n  = tsize_q;
		loads_n  = loads_q;
		exch_n   = exch_q;
		dsize_n  = dsize_q;
		mode_n   = mode_q;
		eotie_n  = eotie_q;
		txh_n    = txh_q;
		txf_n    = txf_q;
		rxh_n    = rxh_q;
		rxf_n    = rxf_q;
		flags_n  = flags_q;
		rdata    = '0;
		res.mosi_valid = 1'b0;
		res.mosi_byte  = '0;

		unique case (item.func)
			FUNC_WRITE: begin
				unique case (item.reg_offset)
					OFF_CR1: begin
						enable_n = d[CR1_SPE];
						if (!d[CR1_SPE]) begin
							// Clearing SPE aborts the transfer but keeps the flags.
							active_n = 1'b0;
							loads_n  = '0;
							exch_n   = '0;
							txf_n    = 1'b0;
							rxf_n    = 1'b0;
						end else if (d[CTRL_START] && !active_q && tsize_q != '0) begin
							active_n = 1'b1;
							loads_n  = tsize_q;
							exch_n   = tsize_q;
						end
					end
					OFF_CR2: begin
						if (!active_q) begin
							tsize_n = d[COUNT_BITS-1:0];
						end
					end
					OFF_CFG1: dsize_n = d[DSIZE_BITS-1:0];
					OFF_CFG2: begin
						mode_n[MB_MASTER] = d[CFG_MASTER];
						mode_n[MB_SSM]    = d[CFG_SOFT_SEL];
						mode_n[MB_CPHA]   = d[CFG_PHASE];
						mode_n[MB_CPOL]   = d[CFG_POLARITY];
						mode_n[MB_LSB]    = d[CFG_LSB_FIRST];
					end
					OFF_IER: eotie_n = d[IRQ_EN_END];
					OFF_IFCR: begin
						if (d[CLR_END]) flags_n[ST_EOT] = 1'b0;
						if (d[IFCR_TXTFC]) flags_n[ST_TXC] = 1'b0;
						if (d[CLR_OVERRUN]) flags_n[ST_OVR] = 1'b0;
					end
					OFF_TXDR: begin
						if (tx_ready) begin
							txh_n   = d[BYTE_BITS-1:0];
							txf_n   = 1'b1;
							loads_n = loads_q - COUNT_BITS'(1);
						end
					end
					default: ;
				endcase
			end
			FUNC_READ: begin
				unique case (item.reg_offset)
					OFF_CR1: begin
						rdata[CR1_SPE]    = enable_q;
						rdata[CTRL_START] = active_q;
					end
					OFF_CR2:  rdata = 32'(tsize_q);
					OFF_CFG1: rdata = 32'(dsize_q);
					OFF_CFG2: begin
						rdata[CFG_MASTER]    = mode_q[MB_MASTER];
						rdata[CFG_LSB_FIRST] = mode_q[MB_LSB];
						rdata[CFG_PHASE]     = mode_q[MB_CPHA];
						rdata[CFG_POLARITY]  = mode_q[MB_CPOL];
						rdata[CFG_SOFT_SEL]  = mode_q[MB_SSM];
					end
					OFF_IER: rdata[IRQ_EN_END] = eotie_q;
					OFF_SR: begin
						rdata[SR_RXP] = rxf_q;
						rdata[SR_TXP] = tx_ready;
						rdata[SR_EOT] = flags_q[ST_EOT];
						rdata[SR_OVR] = flags_q[ST_OVR];
						rdata[SR_TXC] = flags_q[ST_TXC];
					end
					OFF_RXDR: begin
						rxf_n = 1'b0;
						rdata = 32'(rxh_q);
					end
					default: ;
				endcase
			end
			FUNC_TICK: begin
				if (enable_q && active_q && txf_q) begin
					res.mosi_valid = 1'b1;
					res.mosi_byte  = lsb ? bit_rev(txh_q) : txh_q;
					txf_n          = 1'b0;
					if (rxf_q) begin
						flags_n[ST_OVR] = 1'b1;
					end else begin
						rxh_n = lsb ? bit_rev(item.peer_byte) : item.peer_byte;
						rxf_n = 1'b1;
					end
					exch_n = exch_dec;
					if (exch_dec == '0) begin
						flags_n[ST_EOT] = 1'b1;
						flags_n[ST_TXC] = 1'b1;
						active_n        = 1'b0;
						loads_n         = '0;
					end
				end
			end
			default: ;
		endcase

		res.read_data = rdata;
		res.irq       = flags_n[ST_EOT] && eotie_n;
		res.busy_res  = active_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			active_q <= 1'b0;
			tsize_q  <= '0;
			loads_q  <= '0;
			exch_q   <= '0;
			dsize_q  <= '0;
			mode_q   <= '0;
			eotie_q  <= 1'b0;
			txh_q    <= '0;
			txf_q    <= 1'b0;
			rxh_q    <= '0;
			rxf_q    <= 1'b0;
			flags_q  <= '0;
		end else if (fire) begin
			enable_q <= enable_n;
			active_q <= active_n;
			tsize_q  <= tsize_n;
			loads_q  <= loads_n;
			exch_q   <= exch_n;
			dsize_q  <= dsize_n;
			mode_q   <= mode_n;
			eotie_q  <= eotie_n;
			txh_q    <= txh_n;
			txf_q    <= txf_n;
			rxh_q    <= rxh_n;
			rxf_q    <= rxf_n;
			flags_q  <= flags_n;
		end
	end

endmodule

// ===== design/spi_master_register_block_unit.sv =====
// Top level of the SPI master register block: input stage, register core and result register.
// A beat is registered in the input stage, then passes through the core into the result register.
// Throughput: one beat per cycle while out_ready holds; the only loop is the register-core update.
// Input stage and result register hold one beat each, so one more beat is taken while a
// finished result waits; after that in_ready stays low until out_ready returns.
// Reset: arst_n (asynchronous, active low) clears core state and both valid bits, not payloads.
module spi_master_register_block_unit
	import spimrb_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	input  logic [5:0]           reg_offset,
	input  logic [31:0]          write_data,
	input  logic [BYTE_BITS-1:0] peer_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          read_data,
	output logic                 mosi_valid,
	output logic [BYTE_BITS-1:0] mosi_byte,
	output logic                 irq,
	output logic                 busy_res
);

	// Input stage: one beat waits here until the result register has room.
	item_t   item_s1;
	logic    valid_s1;
	// Result register holding the finished beat for the output side.
	result_t result_q;
	logic    out_valid_q;
	result_t res_c;
	logic    adv_s1;
	logic    in_fire;

	// The stage advances into the core whenever the result register is empty or
	// is being emptied in this same cycle. The core state is updated in that cycle,
	// so the next beat always sees the state left by the one before it.
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.func       <= func_t'(func);
			item_s1.reg_offset <= reg_offset;
			item_s1.write_data <= write_data;
			item_s1.peer_byte  <= peer_byte;
		end
	end

	// All register, counter and flag work for a beat happens in one pass here.
	spimrb_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (adv_s1),
		.item  (item_s1),
		.res   (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= res_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = result_q.read_data;
	assign mosi_valid = result_q.mosi_valid;
	assign mosi_byte  = result_q.mosi_byte;
	assign irq        = result_q.irq;
	assign busy_res   = result_q.busy_res;

`ifndef SYNTHESIS
	// An exchange result never carries bus read data.
	a_tick_no_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mosi_valid |-> read_data == '0)
		else $error("exchange beat carries read data");

	// An empty input stage must always take a new beat.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	// A beat leaving the input stage shows up in the result register next cycle.
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid)
		else $error("advanced beat lost before the result register");
`endif

endmodule
